// ===== design/wah_pkg.sv =====
// ---------------------------------------------------------------------------
// wah_pkg: windowed amplitude histogram shared types and constants
// Payload structs, register indexes, controller states and cell control.
// ---------------------------------------------------------------------------
package wah_pkg;

  localparam int MAX_BINS    = 32;
  localparam int SAMPLE_BITS = 16;

  localparam int BIN_W   = $clog2(MAX_BINS);
  localparam int M_W     = $clog2(MAX_BINS + 1);
  localparam int PROD_W  = SAMPLE_BITS + M_W;
  localparam int COUNT_W = 16;
  localparam int WIN_W   = 20;
  localparam int CFG_M_W = 6;
  localparam int CFG_N_W = 16;
  localparam int CFG_W   = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [WIN_W-1:0]   WIN_MAX   = '1;

  localparam logic [CFG_M_W-1:0] BINS_RESET = CFG_M_W'(16);
  localparam logic [CFG_N_W-1:0] LEN_RESET  = CFG_N_W'(1024);

  typedef enum logic [0:0] {
    REG_BIN_COUNT  = 1'b0,
    REG_WINDOW_LEN = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_sample;
  } in_item_t;

  typedef struct packed {
    logic [WIN_W-1:0]   window_index;
    logic [4:0]         bin_index;
    logic [COUNT_W-1:0] bin_total;
    logic               run_end;
  } out_item_t;

  typedef struct packed {
    logic             inc;
    logic [BIN_W-1:0] bin;
    logic             shift;
    logic             clear;
  } cell_ctrl_t;

endpackage

// ===== design/wah_binner.sv =====
// ---------------------------------------------------------------------------
// wah_binner: amplitude bin lookup
// Maps a signed sample to bin (u*m - 1) >> SAMPLE_BITS; flags u == 0.
// ---------------------------------------------------------------------------
module wah_binner (
  input  logic signed [wah_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [wah_pkg::M_W-1:0]                bins_i,
  output logic                                   hit_o,
  output logic [wah_pkg::BIN_W-1:0]              bin_o
);
  import wah_pkg::*;

  logic [SAMPLE_BITS-1:0] u;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      prod_m1;

  // offset binary: u = sample + 2^(S-1)
  assign u       = {~sample_i[SAMPLE_BITS-1], sample_i[SAMPLE_BITS-2:0]};
  assign prod    = PROD_W'(u) * PROD_W'(bins_i);
  assign prod_m1 = prod - PROD_W'(1);
  assign hit_o   = (u != '0);
  assign bin_o   = prod_m1[SAMPLE_BITS +: BIN_W];

endmodule

// ===== design/wah_cell.sv =====
// ---------------------------------------------------------------------------
// wah_cell: one bin counter of the chain
// Counts hits on its bin, saturating; shifts towards bin 0 while draining.
// ---------------------------------------------------------------------------
module wah_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wah_pkg::cell_ctrl_t             ctrl_i,
  input  logic [wah_pkg::BIN_W-1:0]       cell_idx_i,
  input  logic [wah_pkg::COUNT_W-1:0]     nbr_i,
  output logic [wah_pkg::COUNT_W-1:0]     count_o
);
  import wah_pkg::*;

  logic [COUNT_W-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    priority if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.shift) begin
      count_d = nbr_i;
    end else if (ctrl_i.inc && ctrl_i.bin == cell_idx_i && count_q != COUNT_MAX) begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// ===== design/windowed_amplitude_histogram.sv =====
// ---------------------------------------------------------------------------
// windowed_amplitude_histogram: per-window amplitude bin counts
// Throughput: one sample per cycle while no window closes.
// A closing window drains m results, one per cycle while out_stall_i is low, from
// the cycle after the closing sample; a final sample on an exactly full window drains 2m.
// Input stalls while draining; cost is set by the shift chain of bin cells.
// Reset: counters, fill and window index cleared; m = 16, n = 1024.
// ---------------------------------------------------------------------------
module windowed_amplitude_histogram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [wah_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wah_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wah_pkg::out_item_t            out_data_o
);
  import wah_pkg::*;

  logic [CFG_M_W-1:0] bins_cfg_q;
  logic [CFG_N_W-1:0] len_cfg_q;
  logic [M_W-1:0]     m_eff;
  logic [CFG_N_W-1:0] n_eff;

  state_e             state_q, state_d;
  logic [BIN_W-1:0]   emit_cnt_q, emit_cnt_d;
  logic               kind_final_q, kind_final_d;
  logic               pend_final_q, pend_final_d;
  logic [WIN_W-1:0]   win_q, win_d;
  logic [COUNT_W-1:0] fill_q, fill_d;

  logic               in_acc, out_acc;
  logic               bin_hit;
  logic [BIN_W-1:0]   bin_sel;
  logic [COUNT_W-1:0] fill_next;
  logic               win_full;
  logic               last_bin;
  logic               drain_done;
  cell_ctrl_t         ctrl;
  logic [COUNT_W-1:0] cnt [MAX_BINS];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_cfg_q <= BINS_RESET;
      len_cfg_q  <= LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BIN_COUNT:  bins_cfg_q <= cfg_data_i[CFG_M_W-1:0];
        REG_WINDOW_LEN: len_cfg_q  <= cfg_data_i[CFG_N_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (bins_cfg_q == '0) begin
      m_eff = M_W'(1);
    end else if (bins_cfg_q > CFG_M_W'(MAX_BINS)) begin
      m_eff = M_W'(MAX_BINS);
    end else begin
      m_eff = M_W'(bins_cfg_q);
    end
  end

  assign n_eff = (len_cfg_q == '0) ? CFG_N_W'(1) : len_cfg_q;

  wah_binner u_binner (
    .sample_i (in_data_i.sample),
    .bins_i   (m_eff),
    .hit_o    (bin_hit),
    .bin_o    (bin_sel)
  );

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign fill_next  = (fill_q == COUNT_MAX) ? fill_q : fill_q + COUNT_W'(1);
  assign win_full   = fill_next >= n_eff;
  assign last_bin   = ({1'b0, emit_cnt_q} == m_eff - M_W'(1));
  assign drain_done = out_acc && last_bin;

  assign ctrl.inc   = in_acc && bin_hit;
  assign ctrl.bin   = bin_sel;
  assign ctrl.shift = out_acc;
  assign ctrl.clear = drain_done;

  // bin cells: cell 0 feeds the output, zeros enter at the far end
  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    logic [COUNT_W-1:0] nbr;
    if (i == MAX_BINS - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_body
      assign nbr = cnt[i+1];
    end
    wah_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cell_idx_i (BIN_W'(i)),
      .nbr_i      (nbr),
      .count_o    (cnt[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && (win_full || in_data_i.final_sample)) state_d = ST_EMIT;
      ST_EMIT: if (drain_done && !pend_final_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o  = 1'b0;
      ST_EMIT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    emit_cnt_d   = emit_cnt_q;
    kind_final_d = kind_final_q;
    pend_final_d = pend_final_q;
    win_d        = win_q;
    fill_d       = fill_q;
    if (in_acc) begin
      emit_cnt_d = '0;
      if (win_full || in_data_i.final_sample) begin
        fill_d = '0;
      end else begin
        fill_d = fill_next;
      end
      // a full window drains first; the final one (if any) follows
      kind_final_d = !win_full;
      pend_final_d = win_full && in_data_i.final_sample;
    end
    if (out_acc) begin
      emit_cnt_d = emit_cnt_q + BIN_W'(1);
    end
    if (drain_done) begin
      emit_cnt_d = '0;
      if (kind_final_q) begin
        win_d = '0;
      end else begin
        if (win_q != WIN_MAX) win_d = win_q + WIN_W'(1);
        if (pend_final_q) begin
          kind_final_d = 1'b1;
          pend_final_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      emit_cnt_q   <= '0;
      kind_final_q <= 1'b0;
      pend_final_q <= 1'b0;
      win_q        <= '0;
      fill_q       <= '0;
    end else begin
      state_q      <= state_d;
      emit_cnt_q   <= emit_cnt_d;
      kind_final_q <= kind_final_d;
      pend_final_q <= pend_final_d;
      win_q        <= win_d;
      fill_q       <= fill_d;
    end
  end

  assign out_data_o.window_index = win_q;
  assign out_data_o.bin_index    = 5'(emit_cnt_q);
  assign out_data_o.bin_total    = cnt[0];
  assign out_data_o.run_end      = last_bin && !pend_final_q;

`ifndef NO_ASSERTIONS
  a_end_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.run_end) |=> !out_valid_o)
    else $error("result after run end");

  a_bin_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, emit_cnt_q} < m_eff))
    else $error("bin index beyond bin count");

  a_cleared_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_done |=> (cnt[0] == '0))
    else $error("counters not cleared after drain");

  a_no_take_while_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while draining");
`endif

endmodule
